FILE: hdl/atc_pkg.sv
// ----------------------------------------------------------------------------
// AT command line collector package
// Shared widths, result kinds, register indexes and the error code text.
// ----------------------------------------------------------------------------
package atc_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int LEN_W   = 6;
    localparam int CIDX_W  = 3;
    localparam int ERRI_W  = 4;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LINE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd3;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_CR_CHAR  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_LF_CHAR  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_BS_CHAR  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_ECHO     = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_SUPPRESS = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_VERBOSE  = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_CMD_MODE = 3'd6;

    // Register reset values.
    localparam logic [BYTE_W-1:0] RST_CR_CHAR = 8'd13;
    localparam logic [BYTE_W-1:0] RST_LF_CHAR = 8'd10;
    localparam logic [BYTE_W-1:0] RST_BS_CHAR = 8'd8;

    // Index of the final character of each error code form.
    localparam logic [ERRI_W-1:0] ERR_VERB_LAST = 4'd8;
    localparam logic [ERRI_W-1:0] ERR_NUM_LAST  = 4'd1;

    // Character of the error result code at a given position.
    // Verbose form is CR LF "ERROR" CR LF, numeric form is "4" CR.
    function automatic logic [BYTE_W-1:0] err_char(
        input logic              verbose,
        input logic [ERRI_W-1:0] idx,
        input logic [BYTE_W-1:0] cr,
        input logic [BYTE_W-1:0] lf
    );
        logic [BYTE_W-1:0] ch;
        ch = '0;
        if (verbose)
        begin
            case (idx)
                4'd0:    ch = cr;
                4'd1:    ch = lf;
                4'd2:    ch = 8'h45;
                4'd3:    ch = 8'h52;
                4'd4:    ch = 8'h52;
                4'd5:    ch = 8'h4F;
                4'd6:    ch = 8'h52;
                4'd7:    ch = cr;
                4'd8:    ch = lf;
                default: ch = '0;
            endcase
        end
        else
        begin
            case (idx)
                4'd0:    ch = 8'h34;
                4'd1:    ch = cr;
                default: ch = '0;
            endcase
        end
        return ch;
    endfunction

endpackage

FILE: hdl/atc_if.sv
// ----------------------------------------------------------------------------
// AT command line collector channels
// Valid/ready channels for received bytes and for result items.
// ----------------------------------------------------------------------------
interface atc_in_if;
    import atc_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface atc_out_if;
    import atc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  line_length;
    logic              last;

    modport source (output valid, output kind, output out_byte, output line_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input line_length,
                    input last, output ready);
endinterface

FILE: hdl/at_command_line_collector.sv
// ----------------------------------------------------------------------------
// AT command line collector
// Gathers a command line in a RAM, echoes bytes, reports overflow with an
// ERROR result code and hands out the finished line followed by a line end.
// ----------------------------------------------------------------------------
//  Channel   Role    Transaction payload
//  bytes     sink    action, rx_byte
//  results   source  kind, out_byte, line_length, last
//  cfg_*     write   cfg_index selects the register, cfg_data is the value
//
//  A byte is taken only while the sequencer is idle; each result item
//  then goes into the output register. A line byte is first read in
//  S_LRD and forwarded in S_LOUT, as the line RAM read data is registered.
//  Reset clears the line position, the pending flag and the registers; the
//  line RAM is not cleared. A stalled result holds the sequencer in place.
// ----------------------------------------------------------------------------
module at_command_line_collector #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    atc_in_if.sink                    bytes,
    atc_out_if.source                 results,
    input  logic                      cfg_we,
    input  logic [atc_pkg::CIDX_W-1:0] cfg_index,
    input  logic [atc_pkg::BYTE_W-1:0] cfg_data
);
    import atc_pkg::*;

    localparam int PW = $clog2(LINE_DEPTH + 1);
    localparam int AW = $clog2(LINE_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ERR  = 6'b000010,
        S_ECHO = 6'b000100,
        S_LRD  = 6'b001000,
        S_LOUT = 6'b010000,
        S_END  = 6'b100000
    } state_t;

    // Configuration registers.
    logic [BYTE_W-1:0] cr_reg, lf_reg, bs_reg;
    logic              echo_reg, supp_reg, verb_reg, cmd_reg;

    // Line state and sequencer.
    state_t            state_reg, state_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic              pend_reg, pend_next;
    logic [ERRI_W-1:0] err_idx_reg, err_idx_next;
    logic              echo_pend_reg, echo_pend_next;
    logic              disp_reg, disp_next;
    logic [PW-1:0]     len_reg, len_next;
    logic [BYTE_W-1:0] chr_reg, chr_next;
    logic [AW-1:0]     line_idx_reg, line_idx_next;

    // Output register.
    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] obyte_reg;
    logic [LEN_W-1:0]  olen_reg;
    logic              last_reg;

    logic              acc, byte_cmd, is_bs, is_cr, ovf, pend_eff;
    logic [PW-1:0]     pos_eff;
    logic              store_we, err_go, echo_go, disp_go;
    logic              slot_free, push, push_last;
    logic [KIND_W-1:0] push_kind;
    logic [BYTE_W-1:0] push_byte;
    logic [LEN_W-1:0]  push_len;
    logic [ERRI_W-1:0] err_last_idx;
    logic [BYTE_W-1:0] ram_rdata;
    logic              ram_re;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_reg   <= RST_CR_CHAR;
            lf_reg   <= RST_LF_CHAR;
            bs_reg   <= RST_BS_CHAR;
            echo_reg <= 1'b1;
            supp_reg <= 1'b0;
            verb_reg <= 1'b1;
            cmd_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CR_CHAR:  cr_reg   <= cfg_data;
                CFG_LF_CHAR:  lf_reg   <= cfg_data;
                CFG_BS_CHAR:  bs_reg   <= cfg_data;
                CFG_ECHO:     echo_reg <= cfg_data[0];
                CFG_SUPPRESS: supp_reg <= cfg_data[0];
                CFG_VERBOSE:  verb_reg <= cfg_data[0];
                CFG_CMD_MODE: cmd_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Decode of an accepted transaction.
    assign bytes.ready = (state_reg == S_IDLE);
    assign acc         = bytes.valid && bytes.ready;
    assign byte_cmd    = acc && !bytes.action && cmd_reg;
    assign is_bs       = (bytes.rx_byte == bs_reg);
    assign is_cr       = (bytes.rx_byte == cr_reg);
    assign ovf         = (pos_reg == PW'(LINE_DEPTH));
    assign pos_eff     = ovf ? '0 : pos_reg;
    assign pend_eff    = ovf ? 1'b0 : pend_reg;
    assign store_we    = byte_cmd && !is_bs && !is_cr;
    assign err_go      = byte_cmd && !is_bs && ovf && !supp_reg;
    assign echo_go     = byte_cmd && echo_reg;
    assign disp_go     = byte_cmd && !is_bs && is_cr && !pend_eff;

    assign slot_free    = !out_valid_reg || results.ready;
    assign err_last_idx = verb_reg ? ERR_VERB_LAST : ERR_NUM_LAST;
    assign ram_re       = (state_reg == S_LRD);

    // Line store.
    atc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (pos_eff[AW-1:0]),
        .wdata (bytes.rx_byte),
        .re    (ram_re),
        .raddr (line_idx_reg),
        .rdata (ram_rdata)
    );

    // Sequencer: plan at accept time, then emit one result at a time.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        pend_next      = pend_reg;
        err_idx_next   = err_idx_reg;
        echo_pend_next = echo_pend_reg;
        disp_next      = disp_reg;
        len_next       = len_reg;
        chr_next       = chr_reg;
        line_idx_next  = line_idx_reg;
        push           = 1'b0;
        push_kind      = KIND_ECHO;
        push_byte      = '0;
        push_len       = '0;
        push_last      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (acc && bytes.action)
                begin
                    pend_next = 1'b0;
                end
                else if (byte_cmd)
                begin
                    chr_next       = bytes.rx_byte;
                    err_idx_next   = '0;
                    line_idx_next  = '0;
                    echo_pend_next = echo_go;
                    disp_next      = disp_go;
                    len_next       = pos_eff;
                    if (is_bs)
                    begin
                        pos_next = (pos_reg != '0) ? pos_reg - PW'(1) : pos_reg;
                    end
                    else if (is_cr)
                    begin
                        pos_next  = '0;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pos_next  = pos_eff + PW'(1);
                        pend_next = pend_eff;
                    end

                    if (err_go)
                        state_next = S_ERR;
                    else if (echo_go)
                        state_next = S_ECHO;
                    else if (disp_go)
                        state_next = (pos_eff != '0) ? S_LRD : S_END;
                    else
                        state_next = S_IDLE;
                end
            end

            S_ERR:
            begin
                if (slot_free)
                begin
                    push      = 1'b1;
                    push_kind = KIND_CODE;
                    push_byte = err_char(verb_reg, err_idx_reg, cr_reg, lf_reg);
                    push_last = (err_idx_reg == err_last_idx) && !echo_pend_reg && !disp_reg;
                    if (err_idx_reg == err_last_idx)
                    begin
                        if (echo_pend_reg)
                            state_next = S_ECHO;
                        else if (disp_reg)
                            state_next = (len_reg != '0) ? S_LRD : S_END;
                        else
                            state_next = S_IDLE;
                    end
                    else
                    begin
                        err_idx_next = err_idx_reg + ERRI_W'(1);
                    end
                end
            end

            S_ECHO:
            begin
                if (slot_free)
                begin
                    push      = 1'b1;
                    push_kind = KIND_ECHO;
                    push_byte = chr_reg;
                    push_last = !disp_reg;
                    if (disp_reg)
                        state_next = (len_reg != '0) ? S_LRD : S_END;
                    else
                        state_next = S_IDLE;
                end
            end

            S_LRD:
            begin
                state_next = S_LOUT;
            end

            S_LOUT:
            begin
                if (slot_free)
                begin
                    push      = 1'b1;
                    push_kind = KIND_LINE;
                    push_byte = ram_rdata;
                    if (PW'(line_idx_reg) + PW'(1) == len_reg)
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        line_idx_next = line_idx_reg + AW'(1);
                        state_next    = S_LRD;
                    end
                end
            end

            S_END:
            begin
                if (slot_free)
                begin
                    push       = 1'b1;
                    push_kind  = KIND_END;
                    push_len   = LEN_W'(len_reg);
                    push_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            pend_reg  <= pend_next;
            if (push)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Plan and output payload.
    always_ff @(posedge clk)
    begin
        err_idx_reg   <= err_idx_next;
        echo_pend_reg <= echo_pend_next;
        disp_reg      <= disp_next;
        len_reg       <= len_next;
        chr_reg       <= chr_next;
        line_idx_reg  <= line_idx_next;
        if (push)
        begin
            kind_reg  <= push_kind;
            obyte_reg <= push_byte;
            olen_reg  <= push_len;
            last_reg  <= push_last;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.kind        = kind_reg;
    assign results.out_byte    = obyte_reg;
    assign results.line_length = olen_reg;
    assign results.last        = last_reg;

    // The line position never passes the store depth.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(LINE_DEPTH))
        else $error("line position beyond store depth");

    // A line byte is only read below the dispatched length.
    a_line_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOUT) |-> (PW'(line_idx_reg) < len_reg))
        else $error("line read beyond dispatched length");

    // Every RAM read is followed by the cycle that forwards its data.
    a_read_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LRD) |=> (state_reg == S_LOUT))
        else $error("line read not followed by output step");

    // A line end always closes the result sequence.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_END) |-> last_reg)
        else $error("line end item without last flag");

endmodule

FILE: hdl/atc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module atc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: bench/at_command_line_collector_checker.sv
// ----------------------------------------------------------------------------
// AT command line collector checker
// Watches the byte, result and register write ports, keeps its own model of
// the line store, the pending flag and the registers, and compares every
// result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module at_command_line_collector_checker #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    atc_in_if                          bytes_mon,
    atc_out_if                         results_mon,
    input  logic                       cfg_we,
    input  logic [atc_pkg::CIDX_W-1:0] cfg_index,
    input  logic [atc_pkg::BYTE_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         expected_left
);
    import atc_pkg::*;

    localparam int REPORT_LIMIT = 200;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] out_byte;
        logic [LEN_W-1:0]  line_length;
        logic              last;
    } line_result_t;

    // Model of the collector state and its registers.
    logic [BYTE_W-1:0] line_mem [LINE_DEPTH];
    int                line_pos      = 0;
    logic              cmd_pending   = 1'b0;
    logic [BYTE_W-1:0] cr_char       = RST_CR_CHAR;
    logic [BYTE_W-1:0] lf_char       = RST_LF_CHAR;
    logic [BYTE_W-1:0] bs_char       = RST_BS_CHAR;
    logic              echo_on       = 1'b1;
    logic              codes_off     = 1'b0;
    logic              verbose_on    = 1'b1;
    logic              cmd_mode      = 1'b1;

    line_result_t awaited_results [$];
    int           fail_total = 0;

    assign mismatches = fail_total;

    // Queue one predicted result transaction.
    task automatic await_result(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b,
                                input int len);
        line_result_t r;
        r.kind        = kind;
        r.out_byte    = b;
        r.line_length = LEN_W'(len);
        r.last        = 1'b0;
        awaited_results.push_back(r);
    endtask

    // Overflow of the line store: the ERROR code in the selected format.
    task automatic await_error_code();
        string word;
        word = verbose_on ? "ERROR" : "4";
        cmd_pending = 1'b0;
        if (!codes_off)
        begin
            if (verbose_on)
            begin
                await_result(KIND_CODE, cr_char, 0);
                await_result(KIND_CODE, lf_char, 0);
            end
            for (int i = 0; i < word.len(); i++)
                await_result(KIND_CODE, word[i], 0);
            await_result(KIND_CODE, cr_char, 0);
            if (verbose_on)
                await_result(KIND_CODE, lf_char, 0);
        end
    endtask

    // Work out the results of one accepted byte transaction.
    task automatic absorb_byte(input logic act, input logic [BYTE_W-1:0] c);
        int           base;
        line_result_t tail;
        base = awaited_results.size();
        if (act)
            cmd_pending = 1'b0;
        else if (cmd_mode)
        begin
            if (c == bs_char)
            begin
                if (line_pos > 0)
                    line_pos--;
                if (echo_on)
                    await_result(KIND_ECHO, c, 0);
            end
            else
            begin
                if (line_pos >= LINE_DEPTH)
                begin
                    await_error_code();
                    line_pos = 0;
                end
                if (echo_on)
                    await_result(KIND_ECHO, c, 0);
                if (c == cr_char)
                begin
                    // A line that ends while a command is pending is dropped.
                    if (!cmd_pending)
                    begin
                        for (int i = 0; i < line_pos; i++)
                            await_result(KIND_LINE, line_mem[i], 0);
                        await_result(KIND_END, '0, line_pos);
                        cmd_pending = 1'b1;
                    end
                    line_pos = 0;
                end
                else
                begin
                    line_mem[line_pos] = c;
                    line_pos++;
                end
            end
        end
        // The final result of this transaction carries the last flag.
        if (awaited_results.size() > base)
        begin
            tail = awaited_results[awaited_results.size()-1];
            tail.last = 1'b1;
            awaited_results[awaited_results.size()-1] = tail;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
                $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // Compare finished results first, then predict from the accepted byte.
    always @(posedge clk or negedge rst_n)
    begin
        line_result_t want;
        if (!rst_n)
        begin
            line_pos    = 0;
            cmd_pending = 1'b0;
            cr_char     = RST_CR_CHAR;
            lf_char     = RST_LF_CHAR;
            bs_char     = RST_BS_CHAR;
            echo_on     = 1'b1;
            codes_off   = 1'b0;
            verbose_on  = 1'b1;
            cmd_mode    = 1'b1;
            awaited_results.delete();
        end
        else
        begin
            if (results_mon.valid && results_mon.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $error("result transaction with none expected: kind %0d, byte %0d",
                               results_mon.kind, results_mon.out_byte);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("kind", want.kind, results_mon.kind);
                    check_field("out_byte", want.out_byte, results_mon.out_byte);
                    check_field("line_length", want.line_length, results_mon.line_length);
                    check_field("last", want.last, results_mon.last);
                end
            end

            if (bytes_mon.valid && bytes_mon.ready)
                absorb_byte(bytes_mon.action, bytes_mon.rx_byte);

            // Register writes; indexes outside the list are ignored.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CR_CHAR:  cr_char    = cfg_data;
                    CFG_LF_CHAR:  lf_char    = cfg_data;
                    CFG_BS_CHAR:  bs_char    = cfg_data;
                    CFG_ECHO:     echo_on    = cfg_data[0];
                    CFG_SUPPRESS: codes_off  = cfg_data[0];
                    CFG_VERBOSE:  verbose_on = cfg_data[0];
                    CFG_CMD_MODE: cmd_mode   = cfg_data[0];
                    default:      ;
                endcase
            end
        end
        expected_left = awaited_results.size();
    end

endmodule

FILE: bench/at_command_line_collector_tb.sv
// ----------------------------------------------------------------------------
// AT command line collector testbench
// Drives command lines, edits, completions and noise through several
// register settings with random sender bursts and receiver stalls; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module at_command_line_collector_tb;
    import atc_pkg::*;

    localparam int LINE_DEPTH    = 32;
    localparam int RESET_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 40;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 30;
    localparam int LAST_PHASE    = 10;

    localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic              ACT_BYTE   = 1'b0;
    localparam logic              ACT_DONE   = 1'b1;
    localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_T     = 8'h54;

    typedef struct packed {
        logic [BYTE_W-1:0] cr_char;
        logic [BYTE_W-1:0] lf_char;
        logic [BYTE_W-1:0] bs_char;
        logic              echo_on;
        logic              codes_off;
        logic              verbose_on;
        logic              cmd_mode;
    } line_setup_t;

    localparam line_setup_t RESET_SETUP = '{
        cr_char: RST_CR_CHAR, lf_char: RST_LF_CHAR, bs_char: RST_BS_CHAR,
        echo_on: 1'b1, codes_off: 1'b0, verbose_on: 1'b1, cmd_mode: 1'b1
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0] cfg_data;
    int                mismatches;
    int                expected_left;

    bit                hold_request;
    int                burst_left;
    int                items_sent;
    line_setup_t       cur_setup;

    atc_in_if  bytes_ch ();
    atc_out_if results_ch ();

    at_command_line_collector #(
        .LINE_DEPTH (LINE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes_ch),
        .results   (results_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    at_command_line_collector_checker #(
        .LINE_DEPTH (LINE_DEPTH)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .bytes_mon     (bytes_ch),
        .results_mon   (results_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .expected_left (expected_left)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one byte transaction; the sender works in bursts with gaps.
    task automatic offer(input logic act, input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            bytes_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 10);
        end
        else
            @(negedge clk);
        bytes_ch.valid   <= 1'b1;
        bytes_ch.action  <= act;
        bytes_ch.rx_byte <= b;
        burst_left--;
        items_sent++;
        @(posedge clk);
        while (!bytes_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic drain();
        @(negedge clk);
        bytes_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_left != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register writes keep the enable high across back-to-back writes.
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Flag registers get random upper bits, which the block must mask.
    function automatic logic [BYTE_W-1:0] flag_data(input logic flag);
        return {7'($urandom_range(0, 127)), flag};
    endfunction

    task automatic apply_setup(input line_setup_t s);
        write_reg(CFG_CR_CHAR, s.cr_char);
        write_reg(CFG_LF_CHAR, s.lf_char);
        write_reg(CFG_BS_CHAR, s.bs_char);
        write_reg(CFG_ECHO, flag_data(s.echo_on));
        write_reg(CFG_SUPPRESS, flag_data(s.codes_off));
        write_reg(CFG_VERBOSE, flag_data(s.verbose_on));
        write_reg(CFG_CMD_MODE, flag_data(s.cmd_mode));
        write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
        end_writes();
        cur_setup = s;
    endtask

    function automatic line_setup_t phase_setup(input int p);
        line_setup_t s;
        s = RESET_SETUP;
        case (p)
            1: s.echo_on = 1'b0;
            2: s.verbose_on = 1'b0;
            3: s.codes_off = 1'b1;
            4:
            begin
                s.cr_char = 8'h00;
                s.lf_char = 8'hFF;
                s.bs_char = 8'hFF;
            end
            5:
            begin
                s.cr_char    = 8'hFF;
                s.lf_char    = 8'h00;
                s.bs_char    = 8'h00;
                s.echo_on    = 1'b0;
                s.verbose_on = 1'b0;
            end
            // Backspace equal to carriage return.
            6: s.bs_char = s.cr_char;
            default:
            begin
                s.cr_char    = 8'($urandom_range(0, 255));
                s.lf_char    = 8'($urandom_range(0, 255));
                s.bs_char    = 8'($urandom_range(0, 255));
                s.echo_on    = 1'($urandom_range(0, 1));
                s.codes_off  = ($urandom_range(0, 3) == 0);
                s.verbose_on = 1'($urandom_range(0, 1));
            end
        endcase
        return s;
    endfunction

    // A random byte that is neither the line end nor the backspace.
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == cur_setup.cr_char || b == cur_setup.bs_char)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // A command line of the given length, optionally with backspace edits.
    task automatic send_line(input int len, input bit with_edits);
        for (int i = 0; i < len; i++)
        begin
            if (with_edits && i > 0 && $urandom_range(0, 9) == 0)
                offer(ACT_BYTE, cur_setup.bs_char);
            offer(ACT_BYTE, plain_byte());
        end
        offer(ACT_BYTE, cur_setup.cr_char);
    endtask

    // Mostly well-formed lines with completions, the rest noise and edits.
    task automatic run_traffic(input int n_items);
        int target;
        int pick;
        int len;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                len = $urandom_range(0, 19);
                if (len < 16)
                    len = $urandom_range(0, 8);
                else if (len < 19)
                    len = $urandom_range(9, LINE_DEPTH - 1);
                else
                    len = $urandom_range(LINE_DEPTH, LINE_DEPTH + 8);
                send_line(len, len < LINE_DEPTH - 4);
                if ($urandom_range(0, 9) < 6)
                    offer(ACT_DONE, 8'($urandom_range(0, 255)));
            end
            else if (pick < 80)
                offer(ACT_DONE, 8'($urandom_range(0, 255)));
            else if (pick < 90)
                offer(ACT_BYTE, 8'($urandom_range(0, 255)));
            else
            begin
                repeat ($urandom_range(1, 4))
                    offer(ACT_BYTE, cur_setup.bs_char);
                repeat ($urandom_range(1, 3))
                    offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Short directed part at the reset settings.
    task automatic directed_checks();
        // Dispatch, then a line dropped while the command is pending.
        offer(ACT_BYTE, CHAR_A);
        offer(ACT_BYTE, CHAR_T);
        offer(ACT_BYTE, RST_CR_CHAR);
        offer(ACT_BYTE, CHAR_A);
        offer(ACT_BYTE, RST_CR_CHAR);
        offer(ACT_BYTE, RST_CR_CHAR);
        // Completion with the byte field at its extreme.
        offer(ACT_DONE, 8'hFF);
        // Backspace on an empty line.
        offer(ACT_BYTE, RST_BS_CHAR);
        offer(ACT_BYTE, RST_BS_CHAR);
        // Extreme bytes with an edit.
        offer(ACT_BYTE, 8'h00);
        offer(ACT_BYTE, 8'hFF);
        offer(ACT_BYTE, RST_BS_CHAR);
        offer(ACT_BYTE, 8'h7F);
        offer(ACT_BYTE, RST_CR_CHAR);
        offer(ACT_DONE, 8'h00);
        offer(ACT_BYTE, 8'h80);
        offer(ACT_BYTE, 8'h01);
        offer(ACT_BYTE, 8'hAA);
        offer(ACT_BYTE, 8'h55);
        offer(ACT_BYTE, RST_CR_CHAR);
        offer(ACT_DONE, 8'h5A);
        // Empty line dispatches a line end with length zero.
        offer(ACT_BYTE, RST_CR_CHAR);
        offer(ACT_DONE, 8'hA5);
    endtask

    // Receiver: changing stall patterns, and a long hold-off on request.
    initial
    begin
        logic [15:0] stall_pattern;
        int          mode;
        int          mode_left;
        results_ch.ready = 1'b0;
        stall_pattern    = 16'hB3C5;
        mode             = 0;
        mode_left        = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                results_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(64, 256);
                end
                mode_left--;
                stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
                case (mode)
                    0: results_ch.ready <= 1'b1;
                    1: results_ch.ready <= ($urandom_range(0, 9) < 7);
                    2: results_ch.ready <= stall_pattern[0];
                    default: results_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run when nothing is accepted for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (bytes_ch.valid && bytes_ch.ready) ||
                (results_ch.valid && results_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[at_command_line_collector] ERROR");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        bytes_ch.valid   = 1'b0;
        bytes_ch.action  = 1'b0;
        bytes_ch.rx_byte = '0;
        hold_request     = 1'b0;
        burst_left       = 0;
        items_sent       = 0;
        cur_setup        = RESET_SETUP;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        directed_checks();
        // Overflow of the line store at the reset settings.
        send_line(LINE_DEPTH + 2, 1'b0);

        for (int p = 1; p <= LAST_PHASE; p++)
        begin
            drain();
            apply_setup(phase_setup(p));
            // Long receiver hold-off while the sender keeps offering.
            if (p == 2)
            begin
                hold_request = 1'b1;
                send_line(LINE_DEPTH + 4, 1'b0);
            end
            run_traffic(PHASE_ITEMS);
            // Sender pauses until every result has come.
            if (p == 3)
            begin
                drain();
                run_traffic(10);
            end
        end

        // Data mode: bytes are ignored, a completion still clears pending.
        drain();
        apply_setup(RESET_SETUP);
        send_line(2, 1'b0);
        drain();
        write_reg(CFG_CMD_MODE, flag_data(1'b0));
        end_writes();
        cur_setup.cmd_mode = 1'b0;
        repeat (12)
            offer(ACT_BYTE, 8'($urandom_range(0, 255)));
        offer(ACT_BYTE, RST_CR_CHAR);
        offer(ACT_DONE, 8'($urandom_range(0, 255)));
        offer(ACT_BYTE, RST_CR_CHAR);
        drain();
        write_reg(CFG_CMD_MODE, flag_data(1'b1));
        end_writes();
        cur_setup.cmd_mode = 1'b1;
        offer(ACT_BYTE, RST_CR_CHAR);
        run_traffic(20);

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_left == 0)
            $display("[at_command_line_collector] OK");
        else
            $display("[at_command_line_collector] ERROR");
        $finish;
    end

endmodule
